/* rtl/swm_pkg.sv */
// Shared types and constants for the sliding-window median core.
package swm_pkg;

    // Width of the window size register.
    localparam int unsigned CFG_WIDTH = 7;

    // Operation broadcast to every cell of the sorted chain.
    typedef struct packed {
        logic insert;
        logic drop;
    } cell_op_t;

endpackage

/* rtl/swm_cell.sv */
// One cell of the sorted chain: holds a sample and its age, and moves data to or from neighbors.
module swm_cell #(
    parameter int unsigned SAMPLE_WIDTH = 32,
    parameter int unsigned AGE_WIDTH    = 6
) (
    input  logic                           aclk,
    input  swm_pkg::cell_op_t              op,
    input  logic                           live,
    input  logic signed [SAMPLE_WIDTH-1:0] sample,
    input  logic signed [SAMPLE_WIDTH-1:0] rem_val,
    input  logic        [AGE_WIDTH-1:0]    rem_age,
    input  logic                           prev_after,
    input  logic signed [SAMPLE_WIDTH-1:0] prev_val,
    input  logic        [AGE_WIDTH-1:0]    prev_age,
    input  logic signed [SAMPLE_WIDTH-1:0] next_val,
    input  logic        [AGE_WIDTH-1:0]    next_age,
    output logic                           after,
    output logic signed [SAMPLE_WIDTH-1:0] val,
    output logic        [AGE_WIDTH-1:0]    age
);

    logic signed [SAMPLE_WIDTH-1:0] val_reg;
    logic signed [SAMPLE_WIDTH-1:0] val_next;
    logic        [AGE_WIDTH-1:0]    age_reg;
    logic        [AGE_WIDTH-1:0]    age_next;
    logic                           leaves;

    // The new sample belongs somewhere before this cell.
    assign after = live && (sample < val_reg);

    // Cells are ordered by value, and among equal values newer samples sit further right,
    // so every cell at or above the removed entry satisfies this local test.
    assign leaves = live && ((val_reg > rem_val) ||
                             ((val_reg == rem_val) && (age_reg <= rem_age)));

    always_comb begin
        val_next = val_reg;
        age_next = age_reg;
        if (op.insert) begin
            priority if (prev_after) begin
                val_next = prev_val;
                age_next = prev_age + AGE_WIDTH'(1);
            end else if (after || !live) begin
                val_next = sample;
                age_next = '0;
            end else begin
                age_next = age_reg + AGE_WIDTH'(1);
            end
        end else if (op.drop && leaves) begin
            val_next = next_val;
            age_next = next_age;
        end
    end

    always_ff @(posedge aclk) begin
        val_reg <= val_next;
        age_reg <= age_next;
    end

    assign val = val_reg;
    assign age = age_reg;

endmodule

/* rtl/sliding_window_median_core.sv */
// After an input transfer the sample is inserted into the one sorted cell chain and evaluated;
// if the window is then exactly full, the median is registered onto m_tdata, later while
// a previous median is still waiting for m_tready. Once the window is full, each sample takes
// the insert, evaluate and remove steps, while it fills only insert and evaluate; each extra
// drop after the window shrinks adds an evaluate and a remove step; input waits until idle.
// Reset (aresetn low, synchronous) empties the window, sets window_size to 1
// and clears the output valid; sample registers are not cleared.
module sliding_window_median_core #(
    parameter int unsigned MAX_WINDOW   = 64,
    parameter int unsigned SAMPLE_WIDTH = 32
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    cfg_we,
    input  logic [swm_pkg::CFG_WIDTH-1:0]           cfg_wdata,
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]       s_tdata,  // [SAMPLE_WIDTH-1:0] sample
    input  logic [0:0]                              s_tuser,  // [0] restart
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]       m_tdata   // [SAMPLE_WIDTH-1:0] median
);

    localparam int unsigned TDATA_WIDTH = ((SAMPLE_WIDTH + 7) / 8) * 8;
    localparam int unsigned CNT_WIDTH   = $clog2(MAX_WINDOW + 1);
    localparam int unsigned AGE_WIDTH   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_DROP
    } state_t;

    state_t                          state_reg;
    state_t                          state_next;
    logic [swm_pkg::CFG_WIDTH-1:0]   window_reg;
    logic [CNT_WIDTH-1:0]            fill_reg;
    logic [CNT_WIDTH-1:0]            fill_next;
    logic signed [SAMPLE_WIDTH-1:0]  rem_val_reg;
    logic signed [SAMPLE_WIDTH-1:0]  rem_val_next;
    logic [AGE_WIDTH-1:0]            rem_age_reg;
    logic [AGE_WIDTH-1:0]            rem_age_next;
    logic                            last_reg;
    logic                            last_next;
    logic                            m_valid_reg;
    logic                            m_valid_next;
    logic [SAMPLE_WIDTH-1:0]         m_data_reg;
    logic [SAMPLE_WIDTH-1:0]         m_data_next;

    logic                            s_fire;
    logic signed [SAMPLE_WIDTH-1:0]  s_sample;
    logic [CNT_WIDTH-1:0]            fill_eff;
    logic [CNT_WIDTH-1:0]            live_count;
    logic [31:0]                     win32;
    logic [31:0]                     k32;
    logic [CNT_WIDTH-1:0]            k;
    logic [CNT_WIDTH-1:0]            rank;
    logic [AGE_WIDTH-1:0]            oldest_age;
    logic signed [SAMPLE_WIDTH-1:0]  oldest_sel;
    logic signed [SAMPLE_WIDTH-1:0]  median_sel;
    logic                            out_free;
    swm_pkg::cell_op_t               cell_op;

    logic                            cell_after [MAX_WINDOW];
    logic signed [SAMPLE_WIDTH-1:0]  cell_val   [MAX_WINDOW];
    logic [AGE_WIDTH-1:0]            cell_age   [MAX_WINDOW];
    logic                            cell_live  [MAX_WINDOW];

    assign s_tready = (state_reg == S_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign s_sample = signed'(s_tdata[SAMPLE_WIDTH-1:0]);
    assign fill_eff = s_tuser[0] ? '0 : fill_reg;

    // A window size of zero acts as one; sizes above the chain length saturate.
    assign win32 = 32'(window_reg);
    assign k32   = (win32 == 32'd0) ? 32'd1 :
                   (win32 > 32'(MAX_WINDOW)) ? 32'(MAX_WINDOW) : win32;
    assign k     = CNT_WIDTH'(k32);
    assign rank  = (k - CNT_WIDTH'(1)) >> 1;

    assign oldest_age = AGE_WIDTH'(fill_reg - CNT_WIDTH'(1));
    assign out_free   = !m_valid_reg || m_tready;

    assign cell_op.insert = s_fire;
    assign cell_op.drop   = (state_reg == S_DROP);
    assign live_count     = s_fire ? fill_eff : fill_reg;

    // Pick out the oldest live sample and the sample at the median rank.
    always_comb begin
        oldest_sel = '0;
        median_sel = '0;
        for (int i = 0; i < MAX_WINDOW; i++) begin
            if (cell_live[i] && (cell_age[i] == oldest_age)) begin
                oldest_sel = oldest_sel | cell_val[i];
            end
            if (CNT_WIDTH'(i) == rank) begin
                median_sel = median_sel | cell_val[i];
            end
        end
    end

    for (genvar g = 0; g < MAX_WINDOW; g++) begin : g_cell
        logic                           prev_after;
        logic signed [SAMPLE_WIDTH-1:0] prev_val;
        logic [AGE_WIDTH-1:0]           prev_age;
        logic signed [SAMPLE_WIDTH-1:0] next_val;
        logic [AGE_WIDTH-1:0]           next_age;

        assign cell_live[g] = CNT_WIDTH'(g) < live_count;

        if (g == 0) begin : g_first
            assign prev_after = 1'b0;
            assign prev_val   = s_sample;
            assign prev_age   = '0;
        end else begin : g_inner
            assign prev_after = cell_after[g-1];
            assign prev_val   = cell_val[g-1];
            assign prev_age   = cell_age[g-1];
        end

        if (g == MAX_WINDOW - 1) begin : g_last
            assign next_val = cell_val[g];
            assign next_age = cell_age[g];
        end else begin : g_body
            assign next_val = cell_val[g+1];
            assign next_age = cell_age[g+1];
        end

        swm_cell #(
            .SAMPLE_WIDTH(SAMPLE_WIDTH),
            .AGE_WIDTH   (AGE_WIDTH)
        ) u_cell (
            .aclk      (aclk),
            .op        (cell_op),
            .live      (cell_live[g]),
            .sample    (s_sample),
            .rem_val   (rem_val_reg),
            .rem_age   (rem_age_reg),
            .prev_after(prev_after),
            .prev_val  (prev_val),
            .prev_age  (prev_age),
            .next_val  (next_val),
            .next_age  (next_age),
            .after     (cell_after[g]),
            .val       (cell_val[g]),
            .age       (cell_age[g])
        );
    end

    always_comb begin
        state_next   = state_reg;
        fill_next    = fill_reg;
        rem_val_next = rem_val_reg;
        rem_age_next = rem_age_reg;
        last_next    = last_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    fill_next  = fill_eff + CNT_WIDTH'(1);
                    state_next = S_EVAL;
                end
            end
            S_EVAL: begin
                rem_val_next = oldest_sel;
                rem_age_next = oldest_age;
                priority if (fill_reg < k) begin
                    state_next = S_IDLE;
                end else if (fill_reg > k) begin
                    last_next  = 1'b0;
                    state_next = S_DROP;
                end else if (out_free) begin
                    // Window is exactly full: deliver the median, then retire the oldest.
                    m_valid_next = 1'b1;
                    m_data_next  = median_sel;
                    last_next    = 1'b1;
                    state_next   = S_DROP;
                end else begin
                    state_next = S_EVAL;
                end
            end
            S_DROP: begin
                fill_next  = fill_reg - CNT_WIDTH'(1);
                state_next = last_reg ? S_IDLE : S_EVAL;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            fill_reg    <= '0;
            last_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
            window_reg  <= swm_pkg::CFG_WIDTH'(1);
        end else begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            last_reg    <= last_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                window_reg <= cfg_wdata;
            end
        end
        rem_val_reg <= rem_val_next;
        rem_age_reg <= rem_age_next;
        m_data_reg  <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = TDATA_WIDTH'(m_data_reg);

`ifndef SYNTHESIS
    // There is always room in the chain for the next sample.
    a_idle_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |-> (fill_reg < CNT_WIDTH'(MAX_WINDOW)))
        else $error("window holds too many samples while idle");

    // Removal never runs on an empty window.
    a_drop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DROP) |-> (fill_reg != '0))
        else $error("removal from an empty window");

    // Every accepted sample is evaluated in the next cycle.
    a_accept_eval: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> (state_reg == S_EVAL))
        else $error("accepted sample was not evaluated");

    // A result is issued only when the window was exactly full.
    a_result_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EVAL && m_valid_next && !(m_valid_reg && !m_tready))
            |-> (fill_reg == k))
        else $error("result issued from a window that was not full");
`endif

endmodule
